FILE: rtl/core/gfa_pkg.sv
// gfa_pkg: request types, sequencer states and constants of the gravity force accumulator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gfa_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [31:0] THRESH_RESET =
    32'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

  localparam int MUL_W = 96;  // shift-add product width
  localparam int MLT_W = 48;  // multiplier operand width
  localparam int DEN_W = 66;  // squared distance width
  localparam int Q_W   = 47;  // kept quotient bits

  localparam logic [47:0] SAT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SAT_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        body_mass;
    logic               include_req;
    logic               exempt;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic               remove;
  } out_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_PROD,
    S_NUM,
    S_DIV,
    S_ACC,
    S_THR,
    S_MAG,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/gravity_force_accumulator_core.sv
// gravity_force_accumulator_core: sums pairwise gravity terms for one subject body
// depends on gfa_pkg; bit-serial shift-add multiplier and one-bit restoring divider
// an included body takes three 33-step squares, a 32-step mass product, then per axis
// a 33-step product and a 96-step division; a last request adds the threshold square
// and three magnitude squares for the magnitude test. multiplier steps end early when
// the operand runs out
// one request at a time; a finished result waits in the output register
// reset (synchronous, rst_n low): subject and sums zero, threshold 0.0001
`timescale 1ns / 1ps
`default_nettype none

module gravity_force_accumulator_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire gfa_pkg::in_req_t in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output gfa_pkg::out_req_t  out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [31:0]        cfg_data
);

  gfa_pkg::state_t state_r, state_nxt;

  logic signed [31:0] subj_pos_r [3];
  logic signed [31:0] subj_pos_nxt [3];
  logic [31:0]        subj_w_r, subj_w_nxt;
  logic               subj_ex_r, subj_ex_nxt;
  logic signed [47:0] sum_r [3];
  logic signed [47:0] sum_nxt [3];
  logic [31:0]        thr_r, thr_nxt;

  logic [32:0]        dmag_r [3];
  logic [32:0]        dmag_nxt [3];
  logic [2:0]         dneg_r, dneg_nxt;
  logic [31:0]        mass_r, mass_nxt;
  logic               last_r, last_nxt;
  logic [1:0]         axis_r, axis_nxt;

  logic [gfa_pkg::MUL_W-1:0] mul_a_r, mul_a_nxt;
  logic [gfa_pkg::MLT_W-1:0] mul_b_r, mul_b_nxt;
  logic [gfa_pkg::MUL_W-1:0] acc_r, acc_nxt;
  logic [gfa_pkg::DEN_W-1:0] dist2_r, dist2_nxt;
  logic [63:0]               prod_r, prod_nxt;
  logic [63:0]               thr2_r, thr2_nxt;
  logic [95:0]               num_r, num_nxt;
  logic [gfa_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [gfa_pkg::Q_W-1:0]   q_r, q_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [6:0]                cnt_r, cnt_nxt;

  logic                      out_valid_r, out_valid_nxt;
  gfa_pkg::out_req_t         out_data_r, out_data_nxt;

  // combinational helpers
  logic                      in_acc;
  logic                      mul_done;
  logic [gfa_pkg::MUL_W-1:0] mul_step;
  logic [gfa_pkg::DEN_W:0]   rem2;
  logic                      div_ge;
  logic [47:0]               term_mag;
  logic [47:0]               term_s;
  logic signed [48:0]        sum49;
  logic [47:0]               sum_sat;
  logic [47:0]               smag [3];
  logic signed [32:0]        diff [3];
  logic [31:0]               in_pos [3];

  assign in_stall  = (state_r != gfa_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mul_done = (mul_b_r == '0);
  assign mul_step = mul_b_r[0] ? (acc_r + mul_a_r) : acc_r;

  assign rem2   = {rem_r, num_r[95]};
  assign div_ge = (rem2 >= {1'b0, dist2_r});

  assign term_mag = ovf_r ? gfa_pkg::SAT_MAX : {1'b0, q_r};
  assign term_s   = dneg_r[axis_r] ? (48'd0 - term_mag) : term_mag;
  assign sum49    = {sum_r[axis_r][47], sum_r[axis_r]} + {term_s[47], term_s};
  assign sum_sat  = (sum49[48] != sum49[47]) ?
                    (sum49[48] ? gfa_pkg::SAT_MIN : gfa_pkg::SAT_MAX) : sum49[47:0];

  assign in_pos[0] = in_data.pos_x;
  assign in_pos[1] = in_data.pos_y;
  assign in_pos[2] = in_data.pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {in_pos[i][31], in_pos[i]} - {subj_pos_r[i][31], subj_pos_r[i]};
      smag[i] = sum_r[i][47] ? (48'd0 - sum_r[i]) : sum_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gfa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      subj_w_r    <= '0;
      subj_ex_r   <= 1'b0;
      thr_r       <= gfa_pkg::THRESH_RESET;
      for (int i = 0; i < 3; i++) begin
        subj_pos_r[i] <= '0;
        sum_r[i]      <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      subj_w_r    <= subj_w_nxt;
      subj_ex_r   <= subj_ex_nxt;
      thr_r       <= thr_nxt;
      for (int i = 0; i < 3; i++) begin
        subj_pos_r[i] <= subj_pos_nxt[i];
        sum_r[i]      <= sum_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dmag_r[i] <= dmag_nxt[i];
    end
    dneg_r     <= dneg_nxt;
    mass_r     <= mass_nxt;
    last_r     <= last_nxt;
    axis_r     <= axis_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    acc_r      <= acc_nxt;
    dist2_r    <= dist2_nxt;
    prod_r     <= prod_nxt;
    thr2_r     <= thr2_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    ovf_r      <= ovf_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    subj_w_nxt    = subj_w_r;
    subj_ex_nxt   = subj_ex_r;
    thr_nxt       = thr_r;
    dneg_nxt      = dneg_r;
    mass_nxt      = mass_r;
    last_nxt      = last_r;
    axis_nxt      = axis_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    acc_nxt       = acc_r;
    dist2_nxt     = dist2_r;
    prod_nxt      = prod_r;
    thr2_nxt      = thr2_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    ovf_nxt       = ovf_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    for (int i = 0; i < 3; i++) begin
      subj_pos_nxt[i] = subj_pos_r[i];
      sum_nxt[i]      = sum_r[i];
      dmag_nxt[i]     = dmag_r[i];
    end

    if (cfg_valid) begin
      thr_nxt = cfg_data;
    end

    unique case (state_r)
      gfa_pkg::S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_data.last;
          // threshold square is the first step of any result
          mul_a_nxt = gfa_pkg::MUL_W'(thr_r);
          mul_b_nxt = gfa_pkg::MLT_W'(thr_r);
          acc_nxt   = '0;
          if (!in_data.op) begin
            for (int i = 0; i < 3; i++) begin
              subj_pos_nxt[i] = in_pos[i];
              sum_nxt[i]      = '0;
            end
            subj_w_nxt  = in_data.body_mass;
            subj_ex_nxt = in_data.exempt;
            if (in_data.last) begin
              state_nxt = gfa_pkg::S_THR;
            end
          end else if (in_data.include_req) begin
            for (int i = 0; i < 3; i++) begin
              dneg_nxt[i] = diff[i][32];
              dmag_nxt[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
            end
            mass_nxt  = in_data.body_mass;
            axis_nxt  = 2'd0;
            mul_a_nxt = gfa_pkg::MUL_W'(dmag_nxt[0]);
            mul_b_nxt = gfa_pkg::MLT_W'(dmag_nxt[0]);
            state_nxt = gfa_pkg::S_SQ;
          end else if (in_data.last) begin
            state_nxt = gfa_pkg::S_THR;
          end
        end
      end

      gfa_pkg::S_SQ: begin
        if (!mul_done) begin
          acc_nxt   = mul_step;
          mul_a_nxt = mul_a_r << 1;
          mul_b_nxt = mul_b_r >> 1;
        end else if (axis_r == 2'd2) begin
          dist2_nxt = acc_r[gfa_pkg::DEN_W-1:0];
          acc_nxt   = '0;
          if (acc_r == '0) begin
            // coincident body adds nothing
            mul_a_nxt = gfa_pkg::MUL_W'(thr_r);
            mul_b_nxt = gfa_pkg::MLT_W'(thr_r);
            state_nxt = last_r ? gfa_pkg::S_THR : gfa_pkg::S_IDLE;
          end else begin
            mul_a_nxt = gfa_pkg::MUL_W'(subj_w_r);
            mul_b_nxt = gfa_pkg::MLT_W'(mass_r);
            state_nxt = gfa_pkg::S_PROD;
          end
        end else begin
          axis_nxt  = axis_r + 2'd1;
          mul_a_nxt = gfa_pkg::MUL_W'(dmag_r[axis_r + 2'd1]);
          mul_b_nxt = gfa_pkg::MLT_W'(dmag_r[axis_r + 2'd1]);
        end
      end

      gfa_pkg::S_PROD: begin
        if (!mul_done) begin
          acc_nxt   = mul_step;
          mul_a_nxt = mul_a_r << 1;
          mul_b_nxt = mul_b_r >> 1;
        end else begin
          prod_nxt  = acc_r[63:0];
          axis_nxt  = 2'd0;
          mul_a_nxt = gfa_pkg::MUL_W'(acc_r[63:0]);
          mul_b_nxt = gfa_pkg::MLT_W'(dmag_r[0]);
          acc_nxt   = '0;
          state_nxt = gfa_pkg::S_NUM;
        end
      end

      gfa_pkg::S_NUM: begin
        if (!mul_done) begin
          acc_nxt   = mul_step;
          mul_a_nxt = mul_a_r << 1;
          mul_b_nxt = mul_b_r >> 1;
        end else begin
          num_nxt   = acc_r[95:0];
          rem_nxt   = '0;
          q_nxt     = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = 7'd95;
          state_nxt = gfa_pkg::S_DIV;
        end
      end

      gfa_pkg::S_DIV: begin
        rem_nxt = div_ge ? gfa_pkg::DEN_W'(rem2 - {1'b0, dist2_r})
                         : gfa_pkg::DEN_W'(rem2);
        q_nxt   = {q_r[gfa_pkg::Q_W-2:0], div_ge};
        ovf_nxt = ovf_r | q_r[gfa_pkg::Q_W-1];
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          state_nxt = gfa_pkg::S_ACC;
        end
      end

      gfa_pkg::S_ACC: begin
        sum_nxt[axis_r] = sum_sat;
        acc_nxt         = '0;
        if (axis_r == 2'd2) begin
          mul_a_nxt = gfa_pkg::MUL_W'(thr_r);
          mul_b_nxt = gfa_pkg::MLT_W'(thr_r);
          state_nxt = last_r ? gfa_pkg::S_THR : gfa_pkg::S_IDLE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          mul_a_nxt = gfa_pkg::MUL_W'(prod_r);
          mul_b_nxt = gfa_pkg::MLT_W'(dmag_r[axis_r + 2'd1]);
          state_nxt = gfa_pkg::S_NUM;
        end
      end

      gfa_pkg::S_THR: begin
        if (!mul_done) begin
          acc_nxt   = mul_step;
          mul_a_nxt = mul_a_r << 1;
          mul_b_nxt = mul_b_r >> 1;
        end else begin
          thr2_nxt  = acc_r[63:0];
          axis_nxt  = 2'd0;
          mul_a_nxt = gfa_pkg::MUL_W'(smag[0]);
          mul_b_nxt = smag[0];
          acc_nxt   = '0;
          state_nxt = gfa_pkg::S_MAG;
        end
      end

      gfa_pkg::S_MAG: begin
        if (!mul_done) begin
          acc_nxt   = mul_step;
          mul_a_nxt = mul_a_r << 1;
          mul_b_nxt = mul_b_r >> 1;
        end else if (axis_r == 2'd2) begin
          state_nxt = gfa_pkg::S_OUT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          mul_a_nxt = gfa_pkg::MUL_W'(smag[axis_r + 2'd1]);
          mul_b_nxt = smag[axis_r + 2'd1];
        end
      end

      gfa_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.force_x = sum_r[0];
          out_data_nxt.force_y = sum_r[1];
          out_data_nxt.force_z = sum_r[2];
          out_data_nxt.remove  = !subj_ex_r &&
                                 (acc_r < gfa_pkg::MUL_W'(thr2_r));
          state_nxt            = gfa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = gfa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
